FILE: sv/hc27_pkg.sv
// ----------------------------------------------------------------------------
// hc27_pkg: shared types, constants and functions for the mod-27 Hill cipher
// Letter decoding and encoding, the mod 27 reduction and the inverse table.
// ----------------------------------------------------------------------------
package hc27_pkg;

  localparam int unsigned ALPHA_SIZE   = 27;
  localparam logic [7:0]  NTILDE_CHAR  = 8'h3B;
  localparam logic [4:0]  NTILDE_INDEX = 5'd14;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 5;

  typedef logic [4:0] letter_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_TL   = 3'd0,
    CFG_KEY_TR   = 3'd1,
    CFG_KEY_BL   = 3'd2,
    CFG_KEY_BR   = 3'd3,
    CFG_DECRYPT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic    bad;
    letter_t idx;
  } letter_dec_t;

  // Reduce a value below 2048 modulo 27. The reciprocal 607/2^14 slightly
  // overestimates 1/27, but never enough to cross an integer in this range.
  function automatic letter_t mod27(input logic [10:0] x);
    logic [20:0] prod;
    logic [6:0]  quo;
    logic [10:0] rem;
    prod = {10'd0, x} * 21'd607;
    quo  = prod[20:14];
    rem  = x - ({4'd0, quo} * 11'd27);
    return rem[4:0];
  endfunction

  // A key register may hold up to 31; fold it into the alphabet.
  function automatic letter_t reduce_key(input letter_t k);
    return (k >= 5'd27) ? letter_t'(k - 5'd27) : k;
  endfunction

  function automatic letter_t neg27(input letter_t v);
    return (v == 5'd0) ? 5'd0 : letter_t'(5'd27 - v);
  endfunction

  function automatic letter_dec_t letter_index(input logic [7:0] ch);
    logic [7:0]  c;
    letter_dec_t res;
    c   = ch;
    res = '{bad: 1'b1, idx: 5'd0};
    if (c inside {[8'h61:8'h7A]}) begin
      c = c - 8'd32;
    end
    if (ch == NTILDE_CHAR) begin
      res = '{bad: 1'b0, idx: NTILDE_INDEX};
    end else if (c inside {[8'h41:8'h4E]}) begin
      res = '{bad: 1'b0, idx: letter_t'(c - 8'h41)};
    end else if (c inside {[8'h4F:8'h5A]}) begin
      res = '{bad: 1'b0, idx: letter_t'(c - 8'h40)};
    end
    return res;
  endfunction

  function automatic logic [7:0] letter_code(input letter_t idx);
    logic [7:0] code;
    case (idx)
      5'd0:    code = 8'h41;
      5'd1:    code = 8'h42;
      5'd2:    code = 8'h43;
      5'd3:    code = 8'h44;
      5'd4:    code = 8'h45;
      5'd5:    code = 8'h46;
      5'd6:    code = 8'h47;
      5'd7:    code = 8'h48;
      5'd8:    code = 8'h49;
      5'd9:    code = 8'h4A;
      5'd10:   code = 8'h4B;
      5'd11:   code = 8'h4C;
      5'd12:   code = 8'h4D;
      5'd13:   code = 8'h4E;
      5'd14:   code = NTILDE_CHAR;
      5'd15:   code = 8'h4F;
      5'd16:   code = 8'h50;
      5'd17:   code = 8'h51;
      5'd18:   code = 8'h52;
      5'd19:   code = 8'h53;
      5'd20:   code = 8'h54;
      5'd21:   code = 8'h55;
      5'd22:   code = 8'h56;
      5'd23:   code = 8'h57;
      5'd24:   code = 8'h58;
      5'd25:   code = 8'h59;
      5'd26:   code = 8'h5A;
      default: code = 8'h41;
    endcase
    return code;
  endfunction

  // Multiplicative inverse modulo 27; zero where none exists.
  function automatic letter_t inverse_mod27(input letter_t v);
    letter_t inv;
    case (v)
      5'd1:    inv = 5'd1;
      5'd2:    inv = 5'd14;
      5'd4:    inv = 5'd7;
      5'd5:    inv = 5'd11;
      5'd7:    inv = 5'd4;
      5'd8:    inv = 5'd17;
      5'd10:   inv = 5'd19;
      5'd11:   inv = 5'd5;
      5'd13:   inv = 5'd25;
      5'd14:   inv = 5'd2;
      5'd16:   inv = 5'd22;
      5'd17:   inv = 5'd8;
      5'd19:   inv = 5'd10;
      5'd20:   inv = 5'd23;
      5'd22:   inv = 5'd16;
      5'd23:   inv = 5'd20;
      5'd25:   inv = 5'd13;
      5'd26:   inv = 5'd26;
      default: inv = 5'd0;
    endcase
    return inv;
  endfunction

endpackage

FILE: sv/hc27_in_if.sv
// ----------------------------------------------------------------------------
// hc27_in_if: message byte channel
// Valid/ready handshake carrying one message byte per item.
// ----------------------------------------------------------------------------
interface hc27_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

FILE: sv/hc27_out_if.sv
// ----------------------------------------------------------------------------
// hc27_out_if: result letter channel
// Valid/ready handshake carrying one result letter and its flags per item.
// ----------------------------------------------------------------------------
interface hc27_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       pair_last;
  logic       key_singular;
  logic       bad_char;

  modport source (output valid, output char_out, output pair_last,
                  output key_singular, output bad_char, input ready);
  modport sink   (input valid, input char_out, input pair_last,
                  input key_singular, input bad_char, output ready);
endinterface

FILE: sv/hill_cipher_2x2_mod27_core.sv
// ----------------------------------------------------------------------------
// hill_cipher_2x2_mod27_core: 2x2 Hill cipher over a 27-letter alphabet
// Pairs message bytes and multiplies each pair by the key or its inverse.
// ----------------------------------------------------------------------------
// The second byte of a pair is captured in the pair register, and the two
// result letters are then registered in the result buffer; the second
// letter is presented once the first has been taken.
// Throughput: one byte per cycle while the output is ready and input is not
// held, set by the two-letter result buffer, which drains one letter per
// cycle while the next pair's first byte comes in. A configuration write
// holds off input while the working matrix is rederived. Reset (synchronous,
// rst_n low) clears key, mode and pairing state.
module hill_cipher_2x2_mod27_core
  import hc27_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  hc27_in_if.sink               in_chan,
  hc27_out_if.source            out_chan
);

  // Configuration registers
  letter_t key_tl_r, key_tr_r, key_bl_r, key_br_r;
  logic    decrypt_r;
  logic    cfg_hold_r;

  // Derived matrix
  letter_t a_red, b_red, c_red, d_red;
  letter_t det_r;
  letter_t inv;
  letter_t m00_nxt, m01_nxt, m10_nxt, m11_nxt;
  letter_t m00_r, m01_r, m10_r, m11_r;
  logic    singular_nxt, singular_r;

  // Pairing state
  letter_dec_t dec;
  letter_t     held_letter_r;
  logic        held_bad_r;
  logic        pending_r;
  logic        in_acc;

  // Pair register ahead of the multiply
  logic    s1_valid_r;
  letter_t s1_p0_r, s1_p1_r;
  logic    s1_bad_r;
  logic    s1_adv;

  // Result buffer
  letter_t     r0, r1;
  logic [7:0]  ch0_r, ch1_r;
  logic        res_singular_r, res_bad_r;
  logic [1:0]  out_cnt_r, out_cnt_nxt;
  logic        out_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_tl_r   <= '0;
      key_tr_r   <= '0;
      key_bl_r   <= '0;
      key_br_r   <= '0;
      decrypt_r  <= 1'b0;
      cfg_hold_r <= 1'b0;
    end else begin
      cfg_hold_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_KEY_TL:  key_tl_r  <= cfg_wdata;
          CFG_KEY_TR:  key_tr_r  <= cfg_wdata;
          CFG_KEY_BL:  key_bl_r  <= cfg_wdata;
          CFG_KEY_BR:  key_br_r  <= cfg_wdata;
          CFG_DECRYPT: decrypt_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  assign a_red = reduce_key(key_tl_r);
  assign b_red = reduce_key(key_tr_r);
  assign c_red = reduce_key(key_bl_r);
  assign d_red = reduce_key(key_br_r);

  // The determinant is registered first; the matrix is registered from it in
  // the following cycle, which the input hold after a write covers.
  always_ff @(posedge clk) begin
    det_r <= mod27(11'(a_red) * 11'(d_red) + 11'd729 - 11'(b_red) * 11'(c_red));
  end

  assign inv = inverse_mod27(det_r);

  always_comb begin
    singular_nxt = 1'b0;
    m00_nxt      = a_red;
    m01_nxt      = b_red;
    m10_nxt      = c_red;
    m11_nxt      = d_red;
    if (decrypt_r) begin
      if (inv == 5'd0) begin
        singular_nxt = 1'b1;
        m00_nxt      = 5'd1;
        m01_nxt      = 5'd0;
        m10_nxt      = 5'd0;
        m11_nxt      = 5'd1;
      end else begin
        m00_nxt = mod27(11'(d_red) * 11'(inv));
        m01_nxt = mod27(11'(neg27(b_red)) * 11'(inv));
        m10_nxt = mod27(11'(neg27(c_red)) * 11'(inv));
        m11_nxt = mod27(11'(a_red) * 11'(inv));
      end
    end
  end

  always_ff @(posedge clk) begin
    m00_r      <= m00_nxt;
    m01_r      <= m01_nxt;
    m10_r      <= m10_nxt;
    m11_r      <= m11_nxt;
    singular_r <= singular_nxt;
  end

  // Unless held, a first byte is taken; a second needs a free pair register.
  assign in_chan.ready = !cfg_hold_r && (!pending_r || !s1_valid_r || s1_adv);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign dec           = letter_index(in_chan.char_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r     <= 1'b0;
      held_letter_r <= '0;
      held_bad_r    <= 1'b0;
    end else if (in_acc) begin
      pending_r <= !pending_r;
      if (!pending_r) begin
        held_letter_r <= dec.idx;
        held_bad_r    <= dec.bad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc && pending_r) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && pending_r) begin
      s1_p0_r  <= held_letter_r;
      s1_p1_r  <= dec.idx;
      s1_bad_r <= held_bad_r | dec.bad;
    end
  end

  assign out_acc = out_chan.valid && out_chan.ready;
  assign s1_adv  = s1_valid_r && ((out_cnt_r == 2'd0) || ((out_cnt_r == 2'd1) && out_acc));

  assign r0 = mod27(11'(m00_r) * 11'(s1_p0_r) + 11'(m01_r) * 11'(s1_p1_r));
  assign r1 = mod27(11'(m10_r) * 11'(s1_p0_r) + 11'(m11_r) * 11'(s1_p1_r));

  always_comb begin
    out_cnt_nxt = out_cnt_r;
    if (out_acc) begin
      out_cnt_nxt = out_cnt_r - 2'd1;
    end
    if (s1_adv) begin
      out_cnt_nxt = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_cnt_r <= 2'd0;
    end else begin
      out_cnt_r <= out_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ch0_r          <= letter_code(r0);
      ch1_r          <= letter_code(r1);
      res_singular_r <= singular_r;
      res_bad_r      <= s1_bad_r;
    end
  end

  assign out_chan.valid        = (out_cnt_r != 2'd0);
  assign out_chan.char_out     = (out_cnt_r == 2'd2) ? ch0_r : ch1_r;
  assign out_chan.pair_last    = (out_cnt_r == 2'd1);
  assign out_chan.key_singular = res_singular_r;
  assign out_chan.bad_char     = res_bad_r;

endmodule
